// ===== src/donut_window_band_normalizer_macros.svh =====
// Assertion macros for the normalizer; clk and rst are taken from the enclosing module.
`ifndef DONUT_WINDOW_BAND_NORMALIZER_MACROS_SVH
`define DONUT_WINDOW_BAND_NORMALIZER_MACROS_SVH

// a in a cycle implies b in the same cycle
`define DWBN_ASSERT_SAME(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a in a cycle implies b in the next cycle
`define DWBN_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== src/dwbn_pkg.sv =====
package dwbn_pkg;

  localparam int BAND_PAIRS = 2;
  localparam int BANDS      = 2 * BAND_PAIRS;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int AVW        = SAMPLE_W + 9;      // Q.8 average or centre
  localparam int DFW        = AVW + 1;           // centre minus average
  localparam int PW         = DFW + GAIN_W + 1;  // difference times gain
  localparam int SCW        = PW - 12;           // product after /4096
  localparam int VW         = 32;                // rescaled Q.8 value

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_WINDOW_DEF = 15;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE  = 4'd0,
    REG_DONUT_SIZE   = 4'd1,
    REG_IMAGE_WIDTH  = 4'd2,
    REG_IMAGE_HEIGHT = 4'd3,
    REG_MASTER_BAND  = 4'd4,
    REG_PRE_NORM_EN  = 4'd5,
    REG_PRE_GAINS    = 4'd6,
    REG_POST_GAINS   = 4'd7
  } reg_index_t;

  localparam logic [3:0]  RST_WINDOW_SIZE  = 4'd5;
  localparam logic [3:0]  RST_DONUT_SIZE   = 4'd1;
  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd2048;
  localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1024;
  localparam logic        RST_MASTER_BAND  = 1'b0;
  localparam logic        RST_PRE_NORM_EN  = 1'b1;
  localparam logic [31:0] RST_PRE_GAINS    = 32'd268439552;
  localparam logic [31:0] RST_POST_GAINS   = 32'd268439552;

  typedef struct packed {
    logic cfg_write;
    logic accept;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic dif_load;
    logic mul_load;
    logic fin_load;
    logic out_load;
  } dwbn_cmd_t;

  typedef struct packed {
    logic avail;
    logic scan_last;
    logic div_done;
    logic out_free;
  } dwbn_status_t;

endpackage

// ===== src/dwbn_ram.sv =====
module dwbn_ram import dwbn_pkg::*; #(
  parameter int W = 64,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dwbn_div.sv =====
// Four-lane restoring divider, one quotient bit per lane per cycle, shared divisor.
module dwbn_div import dwbn_pkg::*; #(
  parameter int SUMW = 24,
  parameter int CW   = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [SUMW-1:0] sum [BANDS],
  input  logic [CW-1:0]          cnt,
  output logic signed [AVW-1:0]  quo [BANDS],
  output logic                   done
);

  localparam int DW  = SUMW + 8;
  localparam int STW = $clog2(DW + 1);

  logic [DW-1:0]  q   [BANDS];
  logic [CW-1:0]  rem [BANDS];
  logic           neg [BANDS];
  logic [CW-1:0]  dvs;
  logic [STW-1:0] step;
  logic           busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [CW:0] t;
    logic        ge;
    if (start) begin
      dvs <= cnt;
      for (int b = 0; b < BANDS; b++) begin
        neg[b] <= sum[b][SUMW-1];
        rem[b] <= '0;
        q[b]   <= {(sum[b][SUMW-1] ? SUMW'(-sum[b]) : SUMW'(sum[b])), 8'd0};
      end
    end else if (busy) begin
      for (int b = 0; b < BANDS; b++) begin
        t      = {rem[b], q[b][DW-1]};
        ge     = (t >= {1'b0, dvs});
        rem[b] <= ge ? CW'(t - {1'b0, dvs}) : CW'(t);
        q[b]   <= {q[b][DW-2:0], ge};
      end
    end
  end

  always_comb begin
    for (int b = 0; b < BANDS; b++) begin
      quo[b] = neg[b] ? -$signed({1'b0, q[b][AVW-2:0]}) : $signed({1'b0, q[b][AVW-2:0]});
    end
  end

endmodule

// ===== src/dwbn_ctrl.sv =====
module dwbn_ctrl import dwbn_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         cfg_valid,
  input  dwbn_status_t st,
  output logic         in_stall,
  output logic         cfg_ready,
  output dwbn_cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_WRITE  = 11'b000_0000_0010,
    S_CENTER = 11'b000_0000_0100,
    S_SCAN   = 11'b000_0000_1000,
    S_FLUSH  = 11'b000_0001_0000,
    S_DIVS   = 11'b000_0010_0000,
    S_DIVW   = 11'b000_0100_0000,
    S_DIF    = 11'b000_1000_0000,
    S_MUL    = 11'b001_0000_0000,
    S_FIN    = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall      = 1'b0;
        cfg_ready     = 1'b1;
        cmd.cfg_write = cfg_valid;
        cmd.accept    = in_valid;
        if (in_valid) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE:  state_next = st.avail ? S_CENTER : S_IDLE;
      S_CENTER: begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_DIVS;
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (st.div_done) begin
          state_next = S_DIF;
        end
      end
      S_DIF: begin
        cmd.dif_load = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        cmd.fin_load = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/dwbn_dp.sv =====
module dwbn_dp import dwbn_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dwbn_cmd_t             cmd,
  output dwbn_status_t          st,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  kind,
  input  logic signed [15:0]    pre_band_zero,
  input  logic signed [15:0]    pre_band_one,
  input  logic signed [15:0]    post_band_zero,
  input  logic signed [15:0]    post_band_one,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    norm_pre_zero,
  output logic signed [15:0]    norm_pre_one,
  output logic signed [15:0]    norm_post_zero,
  output logic signed [15:0]    norm_post_one,
  output logic                  frame_done
);

  localparam int MAXH      = MAX_WINDOW / 2;
  localparam int MAX_SLOTS = 2 * MAXH + 2;
  localparam int SW        = $clog2(MAX_SLOTS);
  localparam int SCNW      = $clog2(MAX_SLOTS + 1);
  localparam int HW        = $clog2(MAXH + 1);
  localparam int KW        = $clog2(2 * MAXH + 1);
  localparam int DNW       = KW + 4;
  localparam int XW        = $clog2(MAX_WIDTH + 1);
  localparam int CLW       = $clog2(MAX_WIDTH);
  localparam int IWW       = (XW > 12) ? XW : 12;
  localparam int RD        = MAX_SLOTS * MAX_WIDTH;
  localparam int AW        = $clog2(RD);
  localparam int NW        = CLW + 16;
  localparam int MAXPOS    = (2 * MAXH + 1) * (2 * MAXH + 1);
  localparam int CW        = $clog2(MAXPOS + 1);
  localparam int SUMW      = SAMPLE_W + CW;
  localparam int WW        = BANDS * SAMPLE_W;
  localparam int XSW       = CLW + 2;
  localparam int YSW       = 18;

  // configuration
  logic [3:0]  window_size, donut_size;
  logic [11:0] image_width;
  logic [15:0] image_height;
  logic        master_band, pre_norm_en;
  logic [31:0] pre_gains, post_gains;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= RST_WINDOW_SIZE;
      donut_size   <= RST_DONUT_SIZE;
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      master_band  <= RST_MASTER_BAND;
      pre_norm_en  <= RST_PRE_NORM_EN;
      pre_gains    <= RST_PRE_GAINS;
      post_gains   <= RST_POST_GAINS;
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:  window_size  <= cfg_data[3:0];
        REG_DONUT_SIZE:   donut_size   <= cfg_data[3:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[15:0];
        REG_MASTER_BAND:  master_band  <= cfg_data[0];
        REG_PRE_NORM_EN:  pre_norm_en  <= cfg_data[0];
        REG_PRE_GAINS:    pre_gains    <= cfg_data;
        REG_POST_GAINS:   post_gains   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cmd.cfg_write && (cfg_index <= REG_POST_GAINS);

  // effective geometry
  logic [HW-1:0]   h;
  logic [2:0]      d2;
  logic [KW-1:0]   two_h;
  logic [SCNW-1:0] slots;
  logic [XW-1:0]   ew;
  logic [15:0]     eh;
  logic [IWW-1:0]  iw_ext;
  logic [NW-1:0]   total, lag;

  always_comb begin
    if (window_size[3:1] > 3'(MAXH)) begin
      h = HW'(MAXH);
    end else begin
      h = HW'(window_size[3:1]);
    end
    d2     = donut_size[3:1];
    two_h  = KW'({h, 1'b0});
    iw_ext = IWW'(image_width);
    if (image_width == 12'd0) begin
      ew = XW'(1);
    end else if (iw_ext > IWW'(MAX_WIDTH)) begin
      ew = XW'(MAX_WIDTH);
    end else begin
      ew = XW'(iw_ext);
    end
    eh = (image_height == 16'd0) ? 16'd1 : image_height;
    if (XW'(ew) < XW'({h, 1'b1})) begin
      slots = SCNW'({h, 1'b1}) + 1'b1;
    end else begin
      slots = SCNW'({h, 1'b1});
    end
    total = NW'(NW'(ew) * NW'(eh));
    lag   = NW'(NW'(h) * NW'(ew)) + NW'(h);
  end

  // raster position counters
  logic [CLW-1:0] in_col, out_col;
  logic [SW-1:0]  in_slot, out_slot;
  logic [15:0]    out_row;
  logic [NW-1:0]  n_cnt, o_cnt;
  logic           is_px, last_out;

  assign is_px    = cmd.accept && !kind && (n_cnt < total);
  assign last_out = ((o_cnt + 1'b1) == total);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit || (cmd.out_load && last_out)) begin
      in_col   <= '0;
      in_slot  <= '0;
      n_cnt    <= '0;
      out_col  <= '0;
      out_slot <= '0;
      out_row  <= '0;
      o_cnt    <= '0;
    end else begin
      if (is_px) begin
        n_cnt <= n_cnt + 1'b1;
        if (XW'(in_col) + 1'b1 >= ew) begin
          in_col  <= '0;
          in_slot <= (SCNW'(in_slot) == slots - 1'b1) ? '0 : in_slot + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cmd.out_load) begin
        o_cnt <= o_cnt + 1'b1;
        if (XW'(out_col) + 1'b1 >= ew) begin
          out_col  <= '0;
          out_row  <= out_row + 1'b1;
          out_slot <= (SCNW'(out_slot) == slots - 1'b1) ? '0 : out_slot + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  assign st.avail = (n_cnt >= total) ? (o_cnt < total)
                                     : ((NW + 1)'(o_cnt) + (NW + 1)'(lag) < (NW + 1)'(n_cnt));

  // window scan address generator
  logic [KW-1:0] ky, kx;
  logic [SW-1:0] yslot, yslot0;
  logic signed [XSW-1:0] xs;
  logic signed [YSW-1:0] ys;
  logic          pos_ok, in_donut;
  logic [AW-1:0] waddr, raddr, paddr, caddr;

  always_comb begin
    if (SCNW'(out_slot) >= SCNW'(h)) begin
      yslot0 = SW'(SCNW'(out_slot) - SCNW'(h));
    end else begin
      yslot0 = SW'(SCNW'(out_slot) + slots - SCNW'(h));
    end
    xs = $signed(XSW'(out_col)) + $signed(XSW'(kx)) - $signed(XSW'(h));
    ys = $signed(YSW'(out_row)) + $signed(YSW'(ky)) - $signed(YSW'(h));
    in_donut = (DNW'(ky) + DNW'(d2) >= DNW'(h)) && (DNW'(ky) <= DNW'(h) + DNW'(d2)) &&
               (DNW'(kx) + DNW'(d2) >= DNW'(h)) && (DNW'(kx) <= DNW'(h) + DNW'(d2));
    pos_ok = (xs >= 0) && (xs < $signed(XSW'(ew))) &&
             (ys >= 0) && (ys < $signed(YSW'(eh))) && !in_donut;
    paddr = AW'((SW + XW)'(yslot) * (SW + XW)'(ew) + (SW + XW)'(xs[CLW-1:0]));
    caddr = AW'((SW + XW)'(out_slot) * (SW + XW)'(ew) + (SW + XW)'(out_col));
    waddr = AW'((SW + XW)'(in_slot) * (SW + XW)'(ew) + (SW + XW)'(in_col));
    raddr = cmd.scan_start ? caddr : paddr;
  end

  assign st.scan_last = (kx == two_h) && (ky == two_h);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ky    <= '0;
      kx    <= '0;
      yslot <= yslot0;
    end else if (cmd.scan_step) begin
      if (kx == two_h) begin
        kx    <= '0;
        ky    <= ky + 1'b1;
        yslot <= (SCNW'(yslot) == slots - 1'b1) ? '0 : yslot + 1'b1;
      end else begin
        kx <= kx + 1'b1;
      end
    end
  end

  logic [WW-1:0] rdata;

  dwbn_ram #(.W(WW), .D(RD)) u_ram (
    .clk   (clk),
    .we    (is_px),
    .waddr (waddr),
    .wdata ({post_band_one, post_band_zero, pre_band_one, pre_band_zero}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // accumulate on returning read beats
  logic p_ctr, p_use;
  logic signed [SUMW-1:0] sum [BANDS];
  logic [CW-1:0]          cnt;
  logic [WW-1:0]          ctr_word;
  logic                   all_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctr <= 1'b0;
      p_use <= 1'b0;
    end else begin
      p_ctr <= cmd.scan_start;
      p_use <= cmd.scan_step && pos_ok;
    end
  end

  always_comb begin
    all_nz = 1'b1;
    for (int b = 0; b < BANDS; b++) begin
      if (rdata[SAMPLE_W*b +: SAMPLE_W] == '0) begin
        all_nz = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_ctr) begin
      ctr_word <= rdata;
      cnt      <= '0;
      for (int b = 0; b < BANDS; b++) begin
        sum[b] <= '0;
      end
    end else if (p_use && all_nz) begin
      cnt <= cnt + 1'b1;
      for (int b = 0; b < BANDS; b++) begin
        sum[b] <= sum[b] + SUMW'($signed(rdata[SAMPLE_W*b +: SAMPLE_W]));
      end
    end
  end

  logic signed [AVW-1:0] quo [BANDS];

  dwbn_div #(.SUMW(SUMW), .CW(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .sum   (sum),
    .cnt   (cnt),
    .quo   (quo),
    .done  (st.div_done)
  );

  // normalize
  logic signed [AVW-1:0] ctrq  [BANDS];
  logic                  ctrnz [BANDS];
  logic signed [AVW-1:0] avg_r [BANDS];
  logic signed [DFW-1:0] dif_r [BANDS];
  logic signed [PW-1:0]  prod  [BANDS];
  logic signed [VW-1:0]  val   [BANDS];
  logic signed [SCW-1:0] sc    [BANDS];
  logic signed [AVW-1:0] avg_m;
  logic signed [AVW-1:0] avg_eff [BAND_PAIRS];
  logic signed [VW-1:0]  val_next [BANDS];
  logic [GAIN_W-1:0]     gain  [BANDS];
  logic signed [PW-1:0]  adj;
  logic                  resc;

  always_comb begin
    for (int b = 0; b < BANDS; b++) begin
      ctrq[b]  = AVW'($signed({ctr_word[SAMPLE_W*b +: SAMPLE_W], 8'd0}));
      ctrnz[b] = (ctr_word[SAMPLE_W*b +: SAMPLE_W] != '0);
    end
    for (int i = 0; i < BAND_PAIRS; i++) begin
      gain[i]              = pre_gains[GAIN_W*(i%2) +: GAIN_W];
      gain[i + BAND_PAIRS] = post_gains[GAIN_W*(i%2) +: GAIN_W];
    end
    for (int b = 0; b < BANDS; b++) begin
      adj   = prod[b] + (prod[b][PW-1] ? PW'(4095) : PW'(0));
      sc[b] = SCW'(adj >>> 12);
    end
    avg_m = master_band ? avg_r[1] : avg_r[0];
    for (int i = 0; i < BAND_PAIRS; i++) begin
      resc = pre_norm_en && (i != int'(master_band)) && ctrnz[i];
      avg_eff[i]  = resc ? avg_m : avg_r[i];
      val_next[i] = resc ? (VW'(avg_m) + VW'(sc[i])) : VW'(ctrq[i]);
    end
    for (int i = 0; i < BAND_PAIRS; i++) begin
      val_next[i + BAND_PAIRS] = ctrnz[i + BAND_PAIRS]
                               ? (VW'(avg_eff[i]) + VW'(sc[i + BAND_PAIRS]))
                               : VW'(ctrq[i + BAND_PAIRS]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dif_load) begin
      for (int b = 0; b < BANDS; b++) begin
        avg_r[b] <= (cnt == '0) ? '0 : quo[b];
        dif_r[b] <= (cnt == '0) ? '0 : (DFW'(ctrq[b]) - DFW'(quo[b]));
      end
    end
    if (cmd.mul_load) begin
      for (int b = 0; b < BANDS; b++) begin
        prod[b] <= PW'(dif_r[b]) * PW'($signed({1'b0, gain[b]}));
      end
    end
    if (cmd.fin_load) begin
      for (int b = 0; b < BANDS; b++) begin
        val[b] <= val_next[b];
      end
    end
  end

  // output register
  logic signed [VW-1:0] fv  [BANDS];
  logic signed [15:0]   sat [BANDS];

  always_comb begin
    for (int b = 0; b < BANDS; b++) begin
      fv[b] = (val[b] + (val[b][VW-1] ? VW'(255) : VW'(0))) >>> 8;
      if (fv[b] > 32767) begin
        sat[b] = 16'sh7fff;
      end else if (fv[b] < -32768) begin
        sat[b] = -16'sh8000;
      end else begin
        sat[b] = fv[b][15:0];
      end
    end
  end

  assign st.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      norm_pre_zero  <= sat[0];
      norm_pre_one   <= sat[1];
      norm_post_zero <= sat[2];
      norm_post_one  <= sat[3];
      frame_done     <= last_out;
    end
  end

endmodule

// ===== src/donut_window_band_normalizer.sv =====
// Channel | Handshake              | Payload
// in      | in_valid / in_stall    | kind, pre_band_zero/one, post_band_zero/one
// out     | out_valid / out_stall  | norm_pre_zero/one, norm_post_zero/one, frame_done
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A beat that yields no result passes only S_IDLE and S_WRITE. A beat that yields a result
// also scans all (2h+1)^2 window positions, h the half window, one position per cycle on
// the line store read port, then runs the shared serial divider.
// rst is synchronous and clears control and configuration to their defaults.
// The output register holds a result across out_stall while the next input beat
// is taken; a finished result waits in the controller only if that register is full.
module donut_window_band_normalizer import dwbn_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic signed [15:0]    pre_band_zero,
  input  logic signed [15:0]    pre_band_one,
  input  logic signed [15:0]    post_band_zero,
  input  logic signed [15:0]    post_band_one,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    norm_pre_zero,
  output logic signed [15:0]    norm_pre_one,
  output logic signed [15:0]    norm_post_zero,
  output logic signed [15:0]    norm_post_one,
  output logic                  frame_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "donut_window_band_normalizer_macros.svh"

  dwbn_cmd_t    cmd;
  dwbn_status_t st;

  // controller: sequences write, window scan, divide and rescale of one beat
  dwbn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .st        (st),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // datapath: config, counters, line store, accumulators, divider, output register
  dwbn_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (kind),
    .pre_band_zero  (pre_band_zero),
    .pre_band_one   (pre_band_one),
    .post_band_zero (post_band_zero),
    .post_band_one  (post_band_one),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .norm_pre_zero  (norm_pre_zero),
    .norm_pre_one   (norm_pre_one),
    .norm_post_zero (norm_post_zero),
    .norm_post_one  (norm_post_one),
    .frame_done     (frame_done)
  );

  // an accepted beat always occupies the block for at least the next cycle
  `DWBN_ASSERT_NEXT(a_busy_after_accept, cmd.accept, in_stall, "no stall after accept")
  // a result is only loaded into a free output register
  `DWBN_ASSERT_SAME(a_load_when_free, cmd.out_load, st.out_free, "output overwritten")
  // a loaded result is offered next cycle
  `DWBN_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid, "loaded result not shown")

endmodule
